### sv/ecal_pkg.sv
// Shared constants, stage record type and month table for the epoch-to-calendar pipeline.
`default_nettype none

package ecal_pkg;

  localparam int SPLIT_STAGES = 9;
  localparam int CAL_STAGES   = 10;

  localparam logic signed [63:0] LEAP_YEAR_SECS = 64'sd31622400;
  localparam logic signed [63:0] LOW_LIMIT  = -64'sd2147483648 * LEAP_YEAR_SECS;
  localparam logic signed [63:0] HIGH_LIMIT = 64'sd2147483647 * LEAP_YEAR_SECS;
  localparam logic [31:0] BASE_SECS = 32'd951868800;

  // 86400 = 128 * 675: the low seven bits split off, the rest divides by 675
  localparam logic [9:0]  D_SEC    = 10'd675;
  localparam logic [65:0] SEC_BIAS = (66'(D_SEC) << 56) - 66'(BASE_SECS);
  localparam logic [31:0] M_SEC    =
    32'(((64'd1 << 40) + 64'(D_SEC) - 64'd1) / 64'(D_SEC));

  localparam logic [17:0] DAYS_400Y = 18'd146097;
  localparam logic [17:0] DAYS_100Y = 18'd36524;
  localparam logic [15:0] DAYS_4Y   = 16'd1461;
  localparam logic [10:0] DAYS_1Y   = 11'd365;
  localparam logic [49:0] DAY_BIAS  =
    50'((64'(DAYS_400Y) << 23) - (64'd1 << 49));
  localparam logic [31:0] M_400Y =
    32'(((64'd1 << 49) + 64'(DAYS_400Y) - 64'd1) / 64'(DAYS_400Y));
  localparam logic [31:0] M_4Y =
    32'(((64'd1 << 27) + 64'(DAYS_4Y) - 64'd1) / 64'(DAYS_4Y));

  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [11:0] SECS_PER_MIN  = 12'd60;
  localparam logic [31:0] M_HOUR =
    32'(((64'd1 << 29) + 64'(SECS_PER_HOUR) - 64'd1) / 64'(SECS_PER_HOUR));
  localparam logic [31:0] M_MIN =
    32'(((64'd1 << 18) + 64'(SECS_PER_MIN) - 64'd1) / 64'(SECS_PER_MIN));

  localparam logic [17:0] DAYS_PER_WEEK = 18'd7;
  localparam logic [17:0] WDAY_BASE     = 18'd3;
  localparam logic [31:0] M_WEEK =
    32'(((64'd1 << 21) + 64'(DAYS_PER_WEEK) - 64'd1) / 64'(DAYS_PER_WEEK));

  localparam logic [9:0]         MAR_TO_JAN = 10'd59;
  localparam logic signed [34:0] YEAR_BIAS  = 35'sd100;
  localparam logic [3:0]         MONTHS     = 4'd12;

  // One record per pipeline stage; each stage fills in the fields it owns.
  typedef struct packed {
    logic                err;
    logic signed [56:0]  ts;
    logic [59:0]         u;
    logic [6:0]          low7;
    logic [29:0]         dx;
    logic [19:0]         dq;
    logic [9:0]          dr;
    logic [59:0]         qs;
    logic [40:0]         v;
    logic [16:0]         secs;
    logic [30:0]         ex;
    logic [12:0]         eq;
    logic [17:0]         er;
    logic [23:0]         qcu;
    logic signed [23:0]  qc;
    logic [17:0]         rd;
    logic [4:0]          qh;
    logic [11:0]         rh;
    logic [5:0]          qm;
    logic [5:0]          sec;
    logic [1:0]          c;
    logic [15:0]         rem1;
    logic signed [34:0]  y400;
    logic [17:0]         x7;
    logic [14:0]         q7;
    logic [2:0]          wday;
    logic [4:0]          q;
    logic [10:0]         rem2;
    logic [1:0]          ry;
    logic [8:0]          rem3;
    logic                leap;
    logic [3:0]          m;
    logic [4:0]          mday;
    logic [8:0]          yday;
    logic signed [34:0]  ysum;
    logic [31:0]         yout;
    logic [3:0]          mon;
  } stage_t;

  // First day of each month in a year that starts on March 1
  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] s;
    unique case (m)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

### sv/ecal_sec_split.sv
// Range check and floor split of epoch seconds into biased day count and second of day.
`default_nettype none

module ecal_sec_split import ecal_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [63:0] epoch_seconds,
  output logic               mid_valid,
  input  logic               mid_ready,
  output stage_t             mid
);

  localparam int NS = SPLIT_STAGES;

  stage_t        stg [1:NS];
  stage_t        nxt [1:NS];
  logic [NS:1]   vld;
  logic [NS:1]   vin;
  logic [NS+1:1] rdy;

  logic [65:0] w;
  logic [63:0] p3, p5, p7;
  logic [49:0] dsum;

  assign vin = {vld[NS-1:1], in_valid};

  // a stage takes a request when it is empty or its occupant moves on
  always_comb begin
    rdy[NS+1] = mid_ready;
    for (int k = NS; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  always_comb begin
    nxt[1]      = '0;
    nxt[1].err  = (epoch_seconds < LOW_LIMIT) || (epoch_seconds > HIGH_LIMIT);
    nxt[1].ts   = epoch_seconds[56:0];

    // rebase and bias so the day division works on a non-negative value
    nxt[2]      = stg[1];
    w           = {{9{stg[1].ts[56]}}, stg[1].ts} + SEC_BIAS;
    nxt[2].u    = {1'b0, w[65:7]};
    nxt[2].low7 = w[6:0];
    nxt[2].dr   = '0;
    nxt[2].qs   = '0;

    nxt[3]      = stg[2];
    nxt[3].dx   = {stg[2].dr, stg[2].u[59:40]};
    p3          = 64'(nxt[3].dx) * 64'(M_SEC);
    nxt[3].dq   = p3[59:40];

    nxt[4]      = stg[3];
    nxt[4].dr   = 10'(stg[3].dx - 30'(stg[3].dq) * 30'(D_SEC));
    nxt[4].qs   = {stg[3].qs[39:0], stg[3].dq};

    nxt[5]      = stg[4];
    nxt[5].dx   = {stg[4].dr, stg[4].u[39:20]};
    p5          = 64'(nxt[5].dx) * 64'(M_SEC);
    nxt[5].dq   = p5[59:40];

    nxt[6]      = stg[5];
    nxt[6].dr   = 10'(stg[5].dx - 30'(stg[5].dq) * 30'(D_SEC));
    nxt[6].qs   = {stg[5].qs[39:0], stg[5].dq};

    nxt[7]      = stg[6];
    nxt[7].dx   = {stg[6].dr, stg[6].u[19:0]};
    p7          = 64'(nxt[7].dx) * 64'(M_SEC);
    nxt[7].dq   = p7[59:40];

    nxt[8]      = stg[7];
    nxt[8].dr   = 10'(stg[7].dx - 30'(stg[7].dq) * 30'(D_SEC));
    nxt[8].qs   = {stg[7].qs[39:0], stg[7].dq};

    // swap the seconds bias for a 400-year-aligned day bias
    nxt[9]      = stg[8];
    dsum        = stg[8].qs[49:0] + DAY_BIAS;
    nxt[9].v    = dsum[40:0];
    nxt[9].secs = {stg[8].dr, stg[8].low7};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (rdy[k]) begin
          vld[k] <= vin[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k <= NS; k++) begin
      if (rdy[k] && vin[k]) begin
        stg[k] <= nxt[k];
      end
    end
  end

  assign in_ready  = rdy[1];
  assign mid_valid = vld[NS];
  assign mid       = stg[NS];

endmodule

`default_nettype wire

### sv/epoch_seconds_to_calendar_unit.sv
// Epoch seconds to broken-down UTC calendar: 400-year split, cycle clamps and output stage.
//
// Usage: present a signed 64-bit count of seconds since 1970-01-01 UTC on
// epoch_seconds with in_valid; a request is taken on a clock edge where
// in_valid and in_ready are both high. Each request yields one result on the
// output channel (out_valid/out_ready): status, year since 1900, month, day,
// weekday, day of year, hour, minute and second. status is 1 with all other
// fields zero when the count or the resulting year is out of range.
// One request is taken every cycle unless a stalled receiver holds the
// pipeline full. The rate is set by the 19-stage pipeline, where each
// stage holds one step of the reciprocal-multiply divisions or one wide
// add, with the short hour, minute and weekday steps running alongside.
// Every stage has its own valid bit and advances when empty or when the
// stage after it advances, so a stalled receiver holds the result in the
// last stage while empty stages upstream keep filling; nothing is dropped
// or repeated. Synchronous reset empties the pipeline; no memory is cleared.
`default_nettype none

module epoch_seconds_to_calendar_unit import ecal_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [63:0] epoch_seconds,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               status,
  output logic signed [31:0] year_since_1900,
  output logic [3:0]         month_index,
  output logic [4:0]         day_of_month,
  output logic [2:0]         weekday,
  output logic [8:0]         day_of_year,
  output logic [4:0]         hour,
  output logic [5:0]         minute,
  output logic [5:0]         second
);

  localparam int NS = CAL_STAGES;

  logic   mid_valid;
  logic   mid_ready;
  stage_t mid;

  stage_t        stg [1:NS];
  stage_t        nxt [1:NS];
  logic [NS:1]   vld;
  logic [NS:1]   vin;
  logic [NS+1:1] rdy;

  logic [63:0] pe1, pe0, ph, pm, pq, p7;
  logic [9:0]  yd;
  logic [3:0]  m2;
  logic        carry;
  logic signed [34:0] yo;
  logic        ovf;
  logic        bad;

  ecal_sec_split u_split (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .epoch_seconds (epoch_seconds),
    .mid_valid     (mid_valid),
    .mid_ready     (mid_ready),
    .mid           (mid)
  );

  assign vin = {vld[NS-1:1], mid_valid};

  always_comb begin
    rdy[NS+1] = out_ready;
    for (int k = NS; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  always_comb begin
    // high digit of the 400-year division; hour estimate alongside
    nxt[1]      = mid;
    nxt[1].ex   = {3'b000, mid.v[40:13]};
    pe1         = 64'(nxt[1].ex) * 64'(M_400Y);
    nxt[1].eq   = pe1[61:49];
    ph          = 64'(mid.secs) * 64'(M_HOUR);
    nxt[1].qh   = ph[33:29];

    nxt[2]      = stg[1];
    nxt[2].er   = 18'(stg[1].ex - 31'(stg[1].eq) * 31'(DAYS_400Y));
    nxt[2].qcu  = {stg[1].eq[10:0], 13'd0};
    nxt[2].rh   = 12'(stg[1].secs - 17'(stg[1].qh) * SECS_PER_HOUR);

    nxt[3]      = stg[2];
    nxt[3].ex   = {stg[2].er, stg[2].v[12:0]};
    pe0         = 64'(nxt[3].ex) * 64'(M_400Y);
    nxt[3].eq   = pe0[61:49];
    pm          = 64'(stg[2].rh) * 64'(M_MIN);
    nxt[3].qm   = pm[23:18];

    // drop the day bias by flipping the top bit of the cycle count
    nxt[4]      = stg[3];
    nxt[4].rd   = 18'(stg[3].ex - 31'(stg[3].eq) * 31'(DAYS_400Y));
    nxt[4].qc   = {~stg[3].qcu[23], stg[3].qcu[22:13], stg[3].eq};
    nxt[4].sec  = 6'(stg[3].rh - 12'(stg[3].qm) * SECS_PER_MIN);

    // century, clamped so the leap day of the 400th year stays in the last one
    nxt[5]      = stg[4];
    priority if (stg[4].rd >= 18'(3 * DAYS_100Y)) begin
      nxt[5].c = 2'd3;
    end else if (stg[4].rd >= 18'(2 * DAYS_100Y)) begin
      nxt[5].c = 2'd2;
    end else if (stg[4].rd >= DAYS_100Y) begin
      nxt[5].c = 2'd1;
    end else begin
      nxt[5].c = 2'd0;
    end
    nxt[5].rem1 = 16'(stg[4].rd - 18'(nxt[5].c) * DAYS_100Y);
    nxt[5].y400 = 35'(stg[4].qc) * 35'sd400;
    nxt[5].x7   = stg[4].rd + WDAY_BASE;

    nxt[6]      = stg[5];
    pq          = 64'(stg[5].rem1) * 64'(M_4Y);
    nxt[6].q    = (pq[31:27] == 5'd25) ? 5'd24 : pq[31:27];
    p7          = 64'(stg[5].x7) * 64'(M_WEEK);
    nxt[6].q7   = p7[35:21];

    nxt[7]      = stg[6];
    nxt[7].rem2 = 11'(stg[6].rem1 - 16'(stg[6].q) * DAYS_4Y);
    nxt[7].wday = 3'(stg[6].x7 - 18'(stg[6].q7) * DAYS_PER_WEEK);

    nxt[8]      = stg[7];
    priority if (stg[7].rem2 >= 11'(3 * DAYS_1Y)) begin
      nxt[8].ry = 2'd3;
    end else if (stg[7].rem2 >= 11'(2 * DAYS_1Y)) begin
      nxt[8].ry = 2'd2;
    end else if (stg[7].rem2 >= DAYS_1Y) begin
      nxt[8].ry = 2'd1;
    end else begin
      nxt[8].ry = 2'd0;
    end
    nxt[8].rem3 = 9'(stg[7].rem2 - 11'(nxt[8].ry) * DAYS_1Y);
    nxt[8].leap = (nxt[8].ry == 2'd0) && (stg[7].q != 5'd0 || stg[7].c == 2'd0);

    nxt[9]      = stg[8];
    nxt[9].m    = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (stg[8].rem3 >= month_start(4'(k))) begin
        nxt[9].m = nxt[9].m + 4'd1;
      end
    end
    nxt[9].mday = 5'(stg[8].rem3 - month_start(nxt[9].m) + 9'd1);
    yd          = 10'(stg[8].rem3) + MAR_TO_JAN + 10'(stg[8].leap);
    if (yd >= 10'(DAYS_1Y) + 10'(stg[8].leap)) begin
      yd = yd - 10'(DAYS_1Y) - 10'(stg[8].leap);
    end
    nxt[9].yday = yd[8:0];
    nxt[9].ysum = stg[8].y400 + 35'(stg[8].c) * 35'sd100
                + 35'(stg[8].q) * 35'sd4 + 35'(stg[8].ry) + YEAR_BIAS;

    // January and February carry into the next calendar year
    nxt[10]     = stg[9];
    m2          = stg[9].m + 4'd2;
    carry       = (m2 >= MONTHS);
    yo          = stg[9].ysum + 35'(carry);
    ovf         = (yo[34:31] != 4'b0000) && (yo[34:31] != 4'b1111);
    bad         = stg[9].err || ovf;
    nxt[10].err = bad;
    if (bad) begin
      nxt[10].yout = '0;
      nxt[10].mon  = '0;
      nxt[10].mday = '0;
      nxt[10].wday = '0;
      nxt[10].yday = '0;
      nxt[10].qh   = '0;
      nxt[10].qm   = '0;
      nxt[10].sec  = '0;
    end else begin
      nxt[10].yout = yo[31:0];
      nxt[10].mon  = carry ? (m2 - MONTHS) : m2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (rdy[k]) begin
          vld[k] <= vin[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k <= NS; k++) begin
      if (rdy[k] && vin[k]) begin
        stg[k] <= nxt[k];
      end
    end
  end

  assign mid_ready       = rdy[1];
  assign out_valid       = vld[NS];
  assign status          = stg[NS].err;
  assign year_since_1900 = stg[NS].yout;
  assign month_index     = stg[NS].mon;
  assign day_of_month    = stg[NS].mday;
  assign weekday         = stg[NS].wday;
  assign day_of_year     = stg[NS].yday;
  assign hour            = stg[NS].qh;
  assign minute          = stg[NS].qm;
  assign second          = stg[NS].sec;

endmodule

`default_nettype wire
